@@ hw/rtl/line_break_opportunity_finder_macros.svh @@
// Assertion macros for the line break opportunity finder RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef LINE_BREAK_OPPORTUNITY_FINDER_MACROS_SVH
`define LINE_BREAK_OPPORTUNITY_FINDER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LBOF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define LBOF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lbof_pkg.sv @@
// Package for the line break opportunity finder: class codes, break kinds,
// the pair table and the structs passed between modules. No dependencies.
package lbof_pkg;

  typedef enum logic [4:0] {
    CL_XX, CL_AL, CL_SP, CL_BK, CL_CR, CL_LF, CL_NL, CL_ZW, CL_WJ,
    CL_GL, CL_BA, CL_HY, CL_BB, CL_B2, CL_OP, CL_CL, CL_CP, CL_QU,
    CL_NS, CL_EX, CL_IS, CL_SY, CL_NU, CL_PR, CL_PO, CL_ID, CL_CM
  } lb_class_e;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_ALLOWED   = 2'd1,
    KIND_MANDATORY = 2'd2
  } break_kind_e;

  localparam int unsigned NumClasses = 27;

  // Row: class before the boundary, column: class after (leftmost bit is XX).
  localparam logic [0:NumClasses-1] PAIR_OK [NumClasses] = '{
    27'b000000000000_11_00000000000_1_0,       // XX
    27'b000000000000_11_00000000000_1_0,       // AL
    27'b11_0000000_111111_00_1_0000_11111,     // SP
    27'b111111111111111111111111111,           // BK
    27'b11111_0_111111111111111111111,         // CR
    27'b111111111111111111111111111,           // LF
    27'b111111111111111111111111111,           // NL
    27'b111_00000_1111111111111111111,         // ZW
    27'b000000000000000000000000000,           // WJ
    27'b000000000000000000000000000,           // GL
    27'b11_0000000000_111_0000000_1111_0,      // BA
    27'b11_0000000000_111_00000000_111_0,      // HY
    27'b000000000000000000000000000,           // BB
    27'b11_0000000000_1_0_1_0000000_1111_0,    // B2
    27'b000000000000000000000000000,           // OP
    27'b11_0000000000_111_0000000_1_00_1_0,    // CL
    27'b11_0000000000_111_0000000000_1_0,      // CP
    27'b000000000000000000000000000,           // QU
    27'b11_0000000000_111_0000000_1111_0,      // NS
    27'b11_0000000000_111_0000000_1111_0,      // EX
    27'b1_0_0000000000_111_00000000_111_0,     // IS
    27'b11_0000000000_111_00000000_111_0,      // SY
    27'b10_0000000000_11_00000000000_1_0,      // NU
    27'b10_0000000000_11_000000000_11_00,      // PR
    27'b10_0000000000_11_000000000_111_0,      // PO
    27'b11_0000000000_111_0000000_11_0_1_0,    // ID
    27'b000000000000_11_00000000000_1_0        // CM
  };

  typedef struct packed {
    logic      have_prev;
    lb_class_e prev_class;
  } lbof_state_t;

  typedef struct packed {
    break_kind_e break_before;
    break_kind_e break_at_end;
    lbof_state_t state_next;
  } lbof_dec_t;

  function automatic logic is_hard(input lb_class_e c);
    return (c == CL_BK) || (c == CL_LF) || (c == CL_NL) || (c == CL_CR);
  endfunction

  function automatic logic pair_allowed(input lb_class_e prev, input lb_class_e nxt);
    logic ok;
    ok = 1'b0;
    if ((prev <= CL_CM) && (nxt <= CL_CM)) begin
      ok = PAIR_OK[prev][nxt];
    end
    return ok;
  endfunction

endpackage

@@ hw/rtl/lbof_if.sv @@
// Valid/ready channel interfaces for the line break opportunity finder.
// Depends on nothing; payload widths are fixed by the item fields.
interface lbof_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        is_last;

  modport source (output valid, output code_point, output is_last, input ready);
  modport sink (input valid, input code_point, input is_last, output ready);
endinterface

interface lbof_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] break_before;
  logic [4:0] char_class;
  logic [1:0] break_at_end;

  modport source (output valid, output break_before, output char_class,
                  output break_at_end, input ready);
  modport sink (input valid, input break_before, input char_class,
                input break_at_end, output ready);
endinterface

@@ hw/rtl/line_break_opportunity_finder.sv @@
// Line break opportunity finder, top level.
// An accepted code point goes through the input register, then classify +
// decide into the result register. Throughput: one code point per cycle
// while the output channel accepts results; back-pressure holds both stages.
// Reset clears both valid flags and the context (start of text).
`include "line_break_opportunity_finder_macros.svh"

module line_break_opportunity_finder import lbof_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbof_in_if.sink    in_ch_i,
  lbof_out_if.source out_ch_o
);

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    break_kind_e break_before;
    lb_class_e   char_class;
    break_kind_e break_at_end;
  } out_item_t;

  // Input register stage
  logic        s1_valid_q, s1_valid_d;
  in_item_t    s1_q;
  // Result register stage
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q;
  // Context carried from one code point to the next
  lbof_state_t state_q;

  logic        in_fire;
  logic        out_free;
  logic        s1_adv;
  lb_class_e   cls;
  lbof_dec_t   dec;

  // The result register frees up when empty or when its transaction completes;
  // the input register then drains into it, so a new item can enter every cycle while the output is not stalled.
  assign out_free = !out_valid_q || out_ch_o.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign in_ch_i.ready = !s1_valid_q || out_free;
  assign in_fire  = in_ch_i.valid && in_ch_i.ready;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_ch_o.ready);

  lbof_classify u_classify (
    .code_point_i (s1_q.code_point),
    .char_class_o (cls)
  );

  lbof_decide u_decide (
    .char_class_i (cls),
    .is_last_i    (s1_q.is_last),
    .state_i      (state_q),
    .dec_o        (dec)
  );

  // Control: valid flags and context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      state_q.have_prev  <= 1'b0;
      state_q.prev_class <= CL_XX;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      // advance the context only when the item moves into the result stage
      if (s1_adv) begin
        state_q <= dec.state_next;
      end
    end
  end

  // Payload: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.code_point <= in_ch_i.code_point;
      s1_q.is_last    <= in_ch_i.is_last;
    end
    if (s1_adv) begin
      out_q.break_before <= dec.break_before;
      out_q.char_class   <= cls;
      out_q.break_at_end <= dec.break_at_end;
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.break_before = out_q.break_before;
  assign out_ch_o.char_class   = out_q.char_class;
  assign out_ch_o.break_at_end = out_q.break_at_end;

  // A full input stage accepts only while it drains in the same cycle.
  `LBOF_ASSERT(a_no_overwrite, !(in_fire && s1_valid_q) || s1_adv,
               "input stage overwritten")
  // The end of a text returns the context to start of text.
  `LBOF_ASSERT_NEXT(a_last_clears, s1_adv && s1_q.is_last, !state_q.have_prev,
                    "context kept past end")
  // The first boundary of a text is never a break.
  `LBOF_ASSERT_NEXT(a_first_none, s1_adv && !state_q.have_prev,
                    out_q.break_before == KIND_NONE, "break at start of text")
  // A shown result carries a valid class code.
  `LBOF_ASSERT(a_class_range, !out_valid_q || (out_q.char_class <= CL_CM),
               "class code out of range")

endmodule

@@ hw/rtl/lbof_classify.sv @@
// Code point classifier: fixed ASCII table, then a first-match range list.
// Depends on lbof_pkg.
module lbof_classify import lbof_pkg::*; (
  input  logic [20:0] code_point_i,
  output lb_class_e   char_class_o
);

  logic [20:0] c;
  assign c = code_point_i;

  always_comb begin
    char_class_o = CL_AL;
    if (c < 21'd128) begin
      case (c[6:0])
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34,
        7'h35, 7'h36, 7'h37, 7'h38, 7'h39: char_class_o = CL_NU;
        7'h09:                        char_class_o = CL_BA;
        7'h0A:                        char_class_o = CL_LF;
        7'h0B, 7'h0C:                 char_class_o = CL_BK;
        7'h0D:                        char_class_o = CL_CR;
        7'h20:                        char_class_o = CL_SP;
        7'h21, 7'h3F:                 char_class_o = CL_EX;
        7'h22, 7'h27:                 char_class_o = CL_QU;
        7'h24, 7'h2B, 7'h5C:          char_class_o = CL_PR;
        7'h25:                        char_class_o = CL_PO;
        7'h28, 7'h5B, 7'h7B:          char_class_o = CL_OP;
        7'h29:                        char_class_o = CL_CP;
        7'h2C, 7'h2E, 7'h3A, 7'h3B:   char_class_o = CL_IS;
        7'h2D:                        char_class_o = CL_HY;
        7'h2F:                        char_class_o = CL_SY;
        7'h5D, 7'h7D:                 char_class_o = CL_CL;
        7'h7C:                        char_class_o = CL_BA;
        default:                      char_class_o = CL_AL;
      endcase
    end
    // first match wins: order of this chain matters where ranges overlap
    else if (c == 21'h00A0)                        char_class_o = CL_GL;
    else if (c == 21'h00A1)                        char_class_o = CL_OP;
    else if (c >= 21'h00A2 && c <= 21'h00A5)       char_class_o = CL_PR;
    else if (c == 21'h00AB)                        char_class_o = CL_QU;
    else if (c == 21'h00AD)                        char_class_o = CL_BA;
    else if (c == 21'h00B0)                        char_class_o = CL_PO;
    else if (c == 21'h00BB)                        char_class_o = CL_QU;
    else if (c == 21'h00BF)                        char_class_o = CL_OP;
    else if (c >= 21'h0300 && c <= 21'h036F)       char_class_o = CL_CM;
    else if (c >= 21'h1AB0 && c <= 21'h1AFF)       char_class_o = CL_CM;
    else if (c >= 21'h1DC0 && c <= 21'h1DFF)       char_class_o = CL_CM;
    else if (c >= 21'h2000 && c <= 21'h2006)       char_class_o = CL_BA;
    else if (c == 21'h2007)                        char_class_o = CL_GL;
    else if (c >= 21'h2008 && c <= 21'h200A)       char_class_o = CL_BA;
    else if (c == 21'h200B)                        char_class_o = CL_ZW;
    else if (c >= 21'h2010 && c <= 21'h2013)       char_class_o = CL_BA;
    else if (c == 21'h2014)                        char_class_o = CL_B2;
    else if (c >= 21'h2018 && c <= 21'h2019)       char_class_o = CL_QU;
    else if (c >= 21'h201C && c <= 21'h201D)       char_class_o = CL_QU;
    else if (c >= 21'h2020 && c <= 21'h2021)       char_class_o = CL_AL;
    else if (c == 21'h2026)                        char_class_o = CL_IS;
    else if (c >= 21'h2028 && c <= 21'h2029)       char_class_o = CL_BK;
    else if (c == 21'h2030)                        char_class_o = CL_PO;
    else if (c >= 21'h2039 && c <= 21'h203A)       char_class_o = CL_QU;
    else if (c == 21'h2044)                        char_class_o = CL_IS;
    else if (c == 21'h2060)                        char_class_o = CL_WJ;
    else if (c >= 21'h20A0 && c <= 21'h20CF)       char_class_o = CL_PR;
    else if (c >= 21'h2190 && c <= 21'h2BFF)       char_class_o = CL_AL;
    else if (c == 21'h3000)                        char_class_o = CL_ID;
    else if (c >= 21'h3001 && c <= 21'h3002)       char_class_o = CL_CL;
    else if (c >= 21'h3008 && c <= 21'h3011)       char_class_o = CL_OP;
    else if (c >= 21'h3014 && c <= 21'h301B)       char_class_o = CL_OP;
    else if (c == 21'h301C)                        char_class_o = CL_NS;
    else if (c >= 21'h3041 && c <= 21'h309F)       char_class_o = CL_ID;
    else if (c >= 21'h30A0 && c <= 21'h30FF)       char_class_o = CL_ID;
    else if (c >= 21'h3400 && c <= 21'h4DBF)       char_class_o = CL_ID;
    else if (c >= 21'h4E00 && c <= 21'h9FFF)       char_class_o = CL_ID;
    else if (c >= 21'hAC00 && c <= 21'hD7AF)       char_class_o = CL_ID;
    else if (c >= 21'hF900 && c <= 21'hFAFF)       char_class_o = CL_ID;
    else if (c >= 21'hFE30 && c <= 21'hFE4F)       char_class_o = CL_ID;
    else if (c == 21'hFEFF)                        char_class_o = CL_WJ;
    else if (c == 21'hFF01)                        char_class_o = CL_EX;
    else if (c == 21'hFF08)                        char_class_o = CL_OP;
    else if (c == 21'hFF09)                        char_class_o = CL_CP;
    else if (c == 21'hFF0C)                        char_class_o = CL_CL;
    else if (c == 21'hFF0E)                        char_class_o = CL_CL;
    else if (c == 21'hFF1F)                        char_class_o = CL_EX;
    else if (c >= 21'hFF00 && c <= 21'hFFEF)       char_class_o = CL_ID;
    else if (c >= 21'h20000 && c <= 21'h3FFFF)     char_class_o = CL_ID;
    else                                           char_class_o = CL_AL;
  end

endmodule

@@ hw/rtl/lbof_decide.sv @@
// Break decision for one boundary: hard breaks, space runs, combining marks,
// then the pair table. Also forms the next context. Depends on lbof_pkg.
module lbof_decide import lbof_pkg::*; (
  input  lb_class_e   char_class_i,
  input  logic        is_last_i,
  input  lbof_state_t state_i,
  output lbof_dec_t   dec_o
);

  lb_class_e   prev;
  lb_class_e   eff;
  lb_class_e   next_prev;
  break_kind_e kind;

  assign prev = state_i.prev_class;

  always_comb begin
    eff = char_class_i;
    // a combining mark with nothing to attach to acts as a letter
    if ((char_class_i == CL_CM) && (!state_i.have_prev || (prev == CL_SP) ||
        (prev == CL_ZW) || is_hard(prev))) begin
      eff = CL_AL;
    end

    kind = KIND_NONE;
    if (state_i.have_prev) begin
      if ((prev == CL_BK) || (prev == CL_LF) || (prev == CL_NL)) begin
        kind = KIND_MANDATORY;
      end else if (prev == CL_CR) begin
        kind = (char_class_i == CL_LF) ? KIND_NONE : KIND_MANDATORY;
      end else if (prev == CL_SP) begin
        if ((eff == CL_SP) || (eff == CL_WJ) || (eff == CL_GL) ||
            (eff == CL_ZW) || is_hard(eff)) begin
          kind = KIND_NONE;
        end else begin
          kind = KIND_ALLOWED;
        end
      end else if (eff == CL_CM) begin
        kind = KIND_NONE;
      end else begin
        kind = pair_allowed(prev, eff) ? KIND_ALLOWED : KIND_NONE;
      end
    end

    next_prev = (eff == CL_CM) ? prev : eff;

    dec_o.break_before = kind;
    dec_o.break_at_end = (is_last_i && is_hard(next_prev)) ? KIND_MANDATORY : KIND_NONE;
    if (is_last_i) begin
      dec_o.state_next.have_prev  = 1'b0;
      dec_o.state_next.prev_class = CL_XX;
    end else begin
      dec_o.state_next.have_prev  = 1'b1;
      dec_o.state_next.prev_class = next_prev;
    end
  end

endmodule
